/* rtl/bb3_pkg.sv */
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared constants and types of the 3x3 box blur: register codes, field
// widths, reset values and the control word that travels down the pipeline.
// ----------------------------------------------------------------------------
package bb3_pkg;

    // default geometry of the line store and of one color channel
    localparam int DEF_MAX_WIDTH    = 1024;
    localparam int DEF_CHANNEL_BITS = 8;

    // port field widths
    localparam int IO_CHANNEL_BITS  = 8;
    localparam int WIDTH_REG_BITS   = 11;
    localparam int HEIGHT_REG_BITS  = 13;
    localparam int CFG_INDEX_BITS   = 4;
    localparam int CFG_DATA_BITS    = 13;

    // register limits and reset values
    localparam int MIN_DIM          = 3;
    localparam int HEIGHT_LIMIT     = 4096;
    localparam int RESET_WIDTH      = 640;
    localparam int RESET_HEIGHT     = 480;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_BITS'(1);

    // per-item control carried beside the pixel data
    typedef struct packed {
        logic valid;    // item produces a result
        logic border;   // pass the center pixel through
        logic last;     // final pixel of the image
    } bb3_ctrl_t;

endpackage

/* rtl/bb3_line_store.sv */
// ----------------------------------------------------------------------------
// bb3_line_store
// Simple dual-port synchronous RAM holding the two previous image rows, one
// entry per column; registered read data.
// ----------------------------------------------------------------------------
module bb3_line_store #(
    parameter int DEPTH     = 1024,
    parameter int ADDR_BITS = 10,
    parameter int DATA_BITS = 48
) (
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/bb3_mean.sv */
// ----------------------------------------------------------------------------
// bb3_mean
// Two-stage mean of a 3x3 window: nine-term channel sums, then division by
// nine as a multiply by a scaled reciprocal. The second stage is the output
// register of the block; border items take the window center instead.
// ----------------------------------------------------------------------------
module bb3_mean #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     en,
    input  bb3_pkg::bb3_ctrl_t                       ctrl_in,
    input  logic [8:0][3*CHANNEL_BITS-1:0]           window,
    output bb3_pkg::bb3_ctrl_t                       ctrl_out,
    output logic [2:0][CHANNEL_BITS-1:0]             result
);

    import bb3_pkg::*;

    localparam int CB         = CHANNEL_BITS;
    localparam int SUM_BITS   = CB + 4;
    localparam int SHIFT      = SUM_BITS + 4;
    localparam int RECIP_BITS = SHIFT - 3;
    localparam int PROD_BITS  = SUM_BITS + RECIP_BITS;
    // ceil(2^SHIFT / 9): error stays below 1/16 of a unit, so the floor is exact
    localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(((1 << SHIFT) + 8) / 9);

    bb3_ctrl_t                       ctrl_a_reg;
    bb3_ctrl_t                       ctrl_b_reg;
    logic [2:0][SUM_BITS-1:0]        sum_next;
    logic [2:0][SUM_BITS-1:0]        sum_reg;
    logic [2:0][CB-1:0]              center_reg;
    logic [2:0][PROD_BITS-1:0]       prod;
    logic [2:0][CB-1:0]              result_next;
    logic [2:0][CB-1:0]              result_reg;

    // nine-term sum per channel
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            sum_next[ch] = '0;
            for (int k = 0; k < 9; k++)
            begin
                sum_next[ch] = sum_next[ch] + SUM_BITS'(window[k][ch*CB +: CB]);
            end
        end
    end

    // divide by nine, or pass the center on the border
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            prod[ch]        = PROD_BITS'(sum_reg[ch]) * PROD_BITS'(RECIP);
            result_next[ch] = ctrl_a_reg.border ? center_reg[ch] : prod[ch][SHIFT +: CB];
        end
    end

    // control of both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_a_reg <= '0;
            ctrl_b_reg <= '0;
        end
        else if (en)
        begin
            ctrl_a_reg <= ctrl_in;
            ctrl_b_reg <= ctrl_a_reg;
        end
    end

    // data of both stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg    <= sum_next;
            center_reg <= window[4];
            result_reg <= result_next;
        end
    end

    assign ctrl_out = ctrl_b_reg;
    assign result   = result_reg;

endmodule

/* rtl/box_blur_3x3_rgb.sv */
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// 3x3 mean blur of a raster-order stream of three-channel pixels.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, always ready) writes image_width (index
//   0) and image_height (index 1), clamped to their ranges; a write to either
//   restarts the frame. Write only while the block is idle.
//   pixel channel (pixel_valid/pixel_ready) takes one pixel per transfer in
//   raster order, then image_width+1 filler items to flush the last rows.
//   blur channel (blur_valid/blur_ready) gives one result per item from item
//   image_width+1 of a frame on; last_pixel marks the final pixel.
// Throughput is one item per clock while the receiver does not stall. The
//   result of pixel p is registered through the line store read at the
//   transfer of item p+image_width+1, then the window shift, sums and divide
//   stages into the output register.
// The line store is a MAX_WIDTH-entry RAM with one read and one write port,
//   read and written back once per item; it needs no clearing after reset.
// Reset clears the counters and pipeline and loads 640x480. When the receiver
//   stalls, the whole pipeline holds and pixel_ready drops with it.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb #(
    parameter int MAX_WIDTH    = bb3_pkg::DEF_MAX_WIDTH,
    parameter int CHANNEL_BITS = bb3_pkg::DEF_CHANNEL_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bb3_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [bb3_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    // pixel stream
    input  logic                                 pixel_valid,
    output logic                                 pixel_ready,
    input  logic [bb3_pkg::IO_CHANNEL_BITS-1:0]  first_channel,
    input  logic [bb3_pkg::IO_CHANNEL_BITS-1:0]  second_channel,
    input  logic [bb3_pkg::IO_CHANNEL_BITS-1:0]  third_channel,
    input  logic                                 filler,
    // blurred stream
    output logic                                 blur_valid,
    input  logic                                 blur_ready,
    output logic [bb3_pkg::IO_CHANNEL_BITS-1:0]  blurred_first,
    output logic [bb3_pkg::IO_CHANNEL_BITS-1:0]  blurred_second,
    output logic [bb3_pkg::IO_CHANNEL_BITS-1:0]  blurred_third,
    output logic                                 last_pixel
);

    import bb3_pkg::*;

    localparam int CB        = CHANNEL_BITS;
    localparam int PIXW      = 3 * CB;
    localparam int ADDR_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WARM_BITS = WIDTH_REG_BITS + 1;
    localparam int IOB       = IO_CHANNEL_BITS;

    // configuration and counters
    logic [WIDTH_REG_BITS-1:0]   width_reg, width_next;
    logic [HEIGHT_REG_BITS-1:0]  height_reg, height_next;
    logic [ADDR_BITS-1:0]        col_reg, col_next;
    logic [WARM_BITS-1:0]        warm_reg, warm_next;
    logic [WIDTH_REG_BITS-1:0]   ocol_reg, ocol_next;
    logic [HEIGHT_REG_BITS-1:0]  orow_reg, orow_next;
    logic [WIDTH_REG_BITS-1:0]   cfg_width;
    logic [HEIGHT_REG_BITS-1:0]  cfg_height;

    // pipeline
    logic                        adv;
    logic                        accept;
    logic                        cfg_write;
    logic                        col_last;
    logic                        emit;
    logic                        ocol_last;
    logic                        orow_last;
    bb3_ctrl_t                   ctrl0;
    logic [PIXW-1:0]             pix0;
    logic [CB+IOB-1:0]           ext0, ext1, ext2;

    logic                        v1_reg;
    bb3_ctrl_t                   ctrl1_reg;
    logic [PIXW-1:0]             pix1_reg;
    logic [ADDR_BITS-1:0]        col1_reg;
    logic                        fwd1_reg;
    logic [PIXW-1:0]             last_mid_reg;
    logic [PIXW-1:0]             last_pix_reg;
    logic [2*PIXW-1:0]           rd_data;
    logic [PIXW-1:0]             up_use, mid_use;

    logic [8:0][PIXW-1:0]        win_reg, win_next;
    bb3_ctrl_t                   ctrl2_reg;

    bb3_ctrl_t                   ctrl_out;
    logic [2:0][CB-1:0]          result;
    logic [CB+IOB-1:0]           oext0, oext1, oext2;

    // handshakes: the whole pipeline moves when the output register can
    assign adv         = !ctrl_out.valid || blur_ready;
    assign pixel_ready = adv;
    assign cfg_ready   = 1'b1;
    assign accept      = pixel_valid && adv;
    assign cfg_write   = cfg_valid && cfg_ready;

    // clamp configuration data
    always_comb
    begin
        cfg_width  = cfg_data[WIDTH_REG_BITS-1:0];
        cfg_height = cfg_data[HEIGHT_REG_BITS-1:0];
        if (32'(cfg_width) < MIN_DIM)
        begin
            cfg_width = WIDTH_REG_BITS'(MIN_DIM);
        end
        else if (32'(cfg_width) > MAX_WIDTH)
        begin
            cfg_width = WIDTH_REG_BITS'(MAX_WIDTH);
        end
        if (32'(cfg_height) < MIN_DIM)
        begin
            cfg_height = HEIGHT_REG_BITS'(MIN_DIM);
        end
        else if (32'(cfg_height) > HEIGHT_LIMIT)
        begin
            cfg_height = HEIGHT_REG_BITS'(HEIGHT_LIMIT);
        end
    end

    // position of the incoming item and of the pixel it completes
    assign col_last  = (32'(col_reg) == 32'(width_reg) - 32'd1);
    assign emit      = (warm_reg == ({1'b0, width_reg} + WARM_BITS'(1)));
    assign ocol_last = (ocol_reg == width_reg - WIDTH_REG_BITS'(1));
    assign orow_last = (orow_reg >= height_reg - HEIGHT_REG_BITS'(1));

    always_comb
    begin
        ctrl0.valid  = emit;
        ctrl0.border = (orow_reg == '0) || orow_last || (ocol_reg == '0) || ocol_last;
        ctrl0.last   = orow_last && ocol_last;
    end

    // incoming pixel, low channel bits only, zero for filler
    assign ext0 = {{CB{1'b0}}, first_channel};
    assign ext1 = {{CB{1'b0}}, second_channel};
    assign ext2 = {{CB{1'b0}}, third_channel};
    assign pix0 = filler ? '0 : {ext2[CB-1:0], ext1[CB-1:0], ext0[CB-1:0]};

    // next values of configuration and counters
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        warm_next   = warm_reg;
        ocol_next   = ocol_reg;
        orow_next   = orow_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:
                begin
                    width_next = cfg_width;
                    col_next   = '0;
                    warm_next  = '0;
                    ocol_next  = '0;
                    orow_next  = '0;
                end
                REG_IMAGE_HEIGHT:
                begin
                    height_next = cfg_height;
                    col_next    = '0;
                    warm_next   = '0;
                    ocol_next   = '0;
                    orow_next   = '0;
                end
                default:
                begin
                    width_next = width_reg;
                end
            endcase
        end
        else if (accept)
        begin
            col_next  = col_last ? '0 : col_reg + ADDR_BITS'(1);
            warm_next = emit ? warm_reg : warm_reg + WARM_BITS'(1);
            if (emit)
            begin
                if (ctrl0.last)
                begin
                    // end of frame: start over
                    col_next  = '0;
                    warm_next = '0;
                    ocol_next = '0;
                    orow_next = '0;
                end
                else if (ocol_last)
                begin
                    ocol_next = '0;
                    orow_next = orow_reg + HEIGHT_REG_BITS'(1);
                end
                else
                begin
                    ocol_next = ocol_reg + WIDTH_REG_BITS'(1);
                end
            end
        end
    end

    // configuration, counters and stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_REG_BITS'(RESET_WIDTH);
            height_reg <= HEIGHT_REG_BITS'(RESET_HEIGHT);
            col_reg    <= '0;
            warm_reg   <= '0;
            ocol_reg   <= '0;
            orow_reg   <= '0;
            v1_reg     <= 1'b0;
            ctrl2_reg  <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            warm_reg   <= warm_next;
            ocol_reg   <= ocol_next;
            orow_reg   <= orow_next;
            if (adv)
            begin
                v1_reg          <= pixel_valid;
                ctrl2_reg.valid <= v1_reg && ctrl1_reg.valid;
                ctrl2_reg.border <= ctrl1_reg.border;
                ctrl2_reg.last  <= ctrl1_reg.last;
            end
        end
    end

    // stage 1 payload, waits for the line store read
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pix1_reg  <= pix0;
            col1_reg  <= col_reg;
            ctrl1_reg <= ctrl0;
            // same column as the item being written back now: forward it
            fwd1_reg  <= v1_reg && (col1_reg == col_reg);
        end
    end

    // line store: {middle row, upper row} per column
    bb3_line_store #(
        .DEPTH     (MAX_WIDTH),
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (2 * PIXW)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (rd_data),
        .wr_en   (adv && v1_reg),
        .wr_addr (col1_reg),
        .wr_data ({pix1_reg, mid_use})
    );

    // read data with forwarding from the previous write-back
    assign up_use  = fwd1_reg ? last_mid_reg : rd_data[PIXW-1:0];
    assign mid_use = fwd1_reg ? last_pix_reg : rd_data[2*PIXW-1:PIXW];

    // window shift: new column enters on the right
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            win_next[k*3]     = win_reg[k*3+1];
            win_next[k*3 + 1] = win_reg[k*3+2];
        end
        win_next[2] = up_use;
        win_next[5] = mid_use;
        win_next[8] = pix1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv && v1_reg)
        begin
            win_reg      <= win_next;
            last_mid_reg <= mid_use;
            last_pix_reg <= pix1_reg;
        end
    end

    // sums, divide and output register
    bb3_mean #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_mean (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .ctrl_in  (ctrl2_reg),
        .window   (win_reg),
        .ctrl_out (ctrl_out),
        .result   (result)
    );

    // output ports
    assign oext0 = {{IOB{1'b0}}, result[0]};
    assign oext1 = {{IOB{1'b0}}, result[1]};
    assign oext2 = {{IOB{1'b0}}, result[2]};

    assign blur_valid     = ctrl_out.valid;
    assign blurred_first  = oext0[IOB-1:0];
    assign blurred_second = oext1[IOB-1:0];
    assign blurred_third  = oext2[IOB-1:0];
    assign last_pixel     = ctrl_out.last;

endmodule

/* dv/bb3_blur_checker.sv */
// ----------------------------------------------------------------------------
// bb3_blur_checker
// Passive checker for the 3x3 box blur. Watches the register, pixel and
// blurred channels, keeps its own line stores and window, predicts each
// blurred pixel as it is triggered and compares every output transfer,
// field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module bb3_blur_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [bb3_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [bb3_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                 pixel_valid,
    input  logic                                 pixel_ready,
    input  logic [bb3_pkg::IO_CHANNEL_BITS-1:0]  first_channel,
    input  logic [bb3_pkg::IO_CHANNEL_BITS-1:0]  second_channel,
    input  logic [bb3_pkg::IO_CHANNEL_BITS-1:0]  third_channel,
    input  logic                                 filler,
    input  logic                                 blur_valid,
    input  logic                                 blur_ready,
    input  logic [bb3_pkg::IO_CHANNEL_BITS-1:0]  blurred_first,
    input  logic [bb3_pkg::IO_CHANNEL_BITS-1:0]  blurred_second,
    input  logic [bb3_pkg::IO_CHANNEL_BITS-1:0]  blurred_third,
    input  logic                                 last_pixel,
    output int                                   fail_count,
    output int                                   pending,
    output int                                   checked,
    output int                                   frames_done
);
    import bb3_pkg::*;

    localparam int LINE_DEPTH  = DEF_MAX_WIDTH;
    localparam int CB          = DEF_CHANNEL_BITS;
    localparam int TAPS        = 9;
    localparam int MAX_REPORTS = 40;

    typedef logic [3*CB-1:0] rgb_t;
    typedef logic [IO_CHANNEL_BITS-1:0] chan_t;

    typedef struct packed {
        chan_t first_val;
        chan_t second_val;
        chan_t third_val;
        logic  last_flag;
    } blur_px_t;

    // line stores two rows and one row back, and the 3x3 window
    rgb_t line_two_back [LINE_DEPTH];
    rgb_t line_one_back [LINE_DEPTH];
    rgb_t window [TAPS];

    int unsigned col_pos;
    int unsigned frame_items;
    int unsigned img_w;
    int unsigned img_h;

    blur_px_t blur_expected [$];

    // shift one item through the stores and window, queue its result if any
    function automatic void predict_blur(input rgb_t px);
        rgb_t        up;
        rgb_t        mid;
        int unsigned idx;
        int unsigned t;
        int unsigned p;
        int unsigned r;
        int unsigned c;
        int unsigned sum;
        logic        border;
        chan_t       ch_out [3];
        blur_px_t    res;

        idx = col_pos % LINE_DEPTH;
        up  = line_two_back[idx];
        mid = line_one_back[idx];
        line_two_back[idx] = mid;
        line_one_back[idx] = px;

        for (int k = 0; k < 3; k++) begin
            window[k*3]   = window[k*3+1];
            window[k*3+1] = window[k*3+2];
        end
        window[2] = up;
        window[5] = mid;
        window[8] = px;

        col_pos++;
        if (col_pos >= img_w)
            col_pos = 0;

        t = frame_items;
        frame_items++;
        if (t < img_w + 1)
            return;

        // center pixel of the window is pixel p of the frame
        p = t - img_w - 1;
        r = p / img_w;
        c = p % img_w;
        border = (r == 0) || (r >= img_h - 1) || (c == 0) || (c == img_w - 1);

        for (int ch = 0; ch < 3; ch++) begin
            if (border) begin
                ch_out[ch] = window[4][ch*CB +: CB];
            end
            else begin
                sum = 0;
                for (int k = 0; k < TAPS; k++)
                    sum += window[k][ch*CB +: CB];
                ch_out[ch] = chan_t'(sum / TAPS);
            end
        end

        res.first_val  = ch_out[0];
        res.second_val = ch_out[1];
        res.third_val  = ch_out[2];
        res.last_flag  = (p == img_w * img_h - 1);
        if (res.last_flag) begin
            col_pos     = 0;
            frame_items = 0;
        end
        blur_expected.push_back(res);
    endfunction

    function automatic void compare_field(input string field, input chan_t want, input chan_t got);
        if (got !== want) begin
            if (fail_count < MAX_REPORTS)
                $display("%0t: %s expected %0d got %0d", $time, field, want, got);
            fail_count++;
        end
    endfunction

    // watch all three channels on the rising edge
    always @(posedge clk or negedge rst_n) begin : watch
        blur_px_t    want;
        int unsigned v;

        if (!rst_n) begin
            for (int i = 0; i < LINE_DEPTH; i++) begin
                line_two_back[i] = '0;
                line_one_back[i] = '0;
            end
            for (int k = 0; k < TAPS; k++)
                window[k] = '0;
            col_pos     = 0;
            frame_items = 0;
            img_w       = RESET_WIDTH;
            img_h       = RESET_HEIGHT;
            blur_expected.delete();
            fail_count  = 0;
            pending     = 0;
            checked     = 0;
            frames_done = 0;
        end
        else begin
            // size register write: clamp and restart the frame
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_IMAGE_WIDTH) begin
                    v = cfg_data[WIDTH_REG_BITS-1:0];
                    img_w = (v < MIN_DIM) ? MIN_DIM : ((v > LINE_DEPTH) ? LINE_DEPTH : v);
                    col_pos     = 0;
                    frame_items = 0;
                end
                else if (cfg_index == REG_IMAGE_HEIGHT) begin
                    v = cfg_data[HEIGHT_REG_BITS-1:0];
                    img_h = (v < MIN_DIM) ? MIN_DIM : ((v > HEIGHT_LIMIT) ? HEIGHT_LIMIT : v);
                    col_pos     = 0;
                    frame_items = 0;
                end
            end

            // pixel transfer: filler items carry zero color
            if (pixel_valid && pixel_ready)
                predict_blur(filler ? rgb_t'(0) : {third_channel, second_channel, first_channel});

            // blurred transfer against the oldest prediction
            if (blur_valid && blur_ready) begin
                if (blur_expected.size() == 0) begin
                    if (fail_count < MAX_REPORTS)
                        $display("%0t: blurred pixel expected none got %0d %0d %0d last %0b",
                                 $time, blurred_first, blurred_second, blurred_third,
                                 last_pixel);
                    fail_count++;
                end
                else begin
                    want = blur_expected.pop_front();
                    compare_field("blurred_first", want.first_val, blurred_first);
                    compare_field("blurred_second", want.second_val, blurred_second);
                    compare_field("blurred_third", want.third_val, blurred_third);
                    compare_field("last_pixel", chan_t'(want.last_flag), chan_t'(last_pixel));
                    checked++;
                    if (want.last_flag)
                        frames_done++;
                end
            end

            pending = blur_expected.size();
        end
    end

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the 3x3 box blur. Streams images of many sizes
// with flush items, random content, fillers inside images and pixel data in
// the flush, writes the size registers between images (clamped values and
// unused indexes too), and lets a side checker predict and compare results.
// ----------------------------------------------------------------------------
module testbench;
    import bb3_pkg::*;

    localparam int RANDOM_ITEMS = 150;
    localparam int HOLD_CYCLES  = 400;

    typedef logic [IO_CHANNEL_BITS-1:0] chan_t;
    typedef logic [CFG_INDEX_BITS-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_BITS-1:0]   cfg_word_t;
    typedef enum {FILL_RANDOM, FILL_EXTREME, FILL_NEAR_EDGE} fill_style_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    cfg_idx_t  cfg_index = '0;
    cfg_word_t cfg_data = '0;
    logic      pixel_valid = 1'b0;
    logic      pixel_ready;
    chan_t     first_channel = '0;
    chan_t     second_channel = '0;
    chan_t     third_channel = '0;
    logic      filler = 1'b0;
    logic      blur_valid;
    logic      blur_ready = 1'b0;
    chan_t     blurred_first;
    chan_t     blurred_second;
    chan_t     blurred_third;
    logic      last_pixel;

    int fail_count;
    int pending;
    int checked;
    int frames_done;

    bit          tx_busy = 1'b1;
    bit          rx_busy = 1'b1;
    int          sink_hold = 0;
    int          items_sent = 0;
    int          reg_writes = 0;
    int unsigned cur_w = RESET_WIDTH;
    int unsigned cur_h = RESET_HEIGHT;

    // 3x3 tile with extremes; the center goes in as a filler
    logic [23:0] mixed_tile [9] = '{24'hFFFFFF, 24'h000000, 24'h8000FF,
                                    24'hFFFE01, 24'hFFFFFF, 24'hFFFFFF,
                                    24'hFFFFFF, 24'h00FF00, 24'h808080};

    box_blur_3x3_rgb dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pixel_valid    (pixel_valid),
        .pixel_ready    (pixel_ready),
        .first_channel  (first_channel),
        .second_channel (second_channel),
        .third_channel  (third_channel),
        .filler         (filler),
        .blur_valid     (blur_valid),
        .blur_ready     (blur_ready),
        .blurred_first  (blurred_first),
        .blurred_second (blurred_second),
        .blurred_third  (blurred_third),
        .last_pixel     (last_pixel)
    );

    bb3_blur_checker blur_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pixel_valid    (pixel_valid),
        .pixel_ready    (pixel_ready),
        .first_channel  (first_channel),
        .second_channel (second_channel),
        .third_channel  (third_channel),
        .filler         (filler),
        .blur_valid     (blur_valid),
        .blur_ready     (blur_ready),
        .blurred_first  (blurred_first),
        .blurred_second (blurred_second),
        .blurred_third  (blurred_third),
        .last_pixel     (last_pixel),
        .fail_count     (fail_count),
        .pending        (pending),
        .checked        (checked),
        .frames_done    (frames_done)
    );

    // clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin : watchdog
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

    // blurred side: random wait per transfer, plus one long hold on request
    initial
    begin : sink
        int gap;

        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = rx_busy ? $urandom_range(0, 5) : 0;
            if (sink_hold > 0)
            begin
                gap = sink_hold;
                sink_hold = 0;
            end
            if (gap > 0)
            begin
                blur_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            blur_ready <= 1'b1;
            do @(posedge clk); while (!blur_valid);
            @(negedge clk);
        end
    end

    function automatic int unsigned dim_clamp(input int unsigned v, input int unsigned hi);
        if (v < MIN_DIM)
            return MIN_DIM;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic chan_t pick_channel(input fill_style_t style);
        case (style)
            FILL_EXTREME:   return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            FILL_NEAR_EDGE: return $urandom_range(0, 1) ? chan_t'($urandom_range(250, 255))
                                                        : chan_t'($urandom_range(0, 5));
            default:        return chan_t'($urandom_range(0, 255));
        endcase
    endfunction

    // one pixel transfer, called and returning at a falling edge
    task automatic send_pixel(input chan_t c0, input chan_t c1, input chan_t c2,
                              input logic fill);
        int gap;

        gap = tx_busy ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pixel_valid    <= 1'b1;
        first_channel  <= c0;
        second_channel <= c1;
        third_channel  <= c2;
        filler         <= fill;
        do @(posedge clk); while (!pixel_ready);
        @(negedge clk);
        items_sent++;
    endtask

    // stop offering pixels and wait until the pipeline is empty
    task automatic drain_pipeline();
        int quiet;

        pixel_valid <= 1'b0;
        wait (pending == 0);
        quiet = 0;
        while (quiet < 8)
        begin
            @(negedge clk);
            quiet = blur_ready ? quiet + 1 : 0;
        end
    endtask

    task automatic write_reg(input cfg_idx_t idx, input cfg_word_t value);
        drain_pipeline();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    task automatic set_width(input cfg_word_t value);
        write_reg(REG_IMAGE_WIDTH, value);
        cur_w = dim_clamp(value[WIDTH_REG_BITS-1:0], DEF_MAX_WIDTH);
    endtask

    task automatic set_height(input cfg_word_t value);
        write_reg(REG_IMAGE_HEIGHT, value);
        cur_h = dim_clamp(value[HEIGHT_REG_BITS-1:0], HEIGHT_LIMIT);
    endtask

    // image of w x h pixels plus flush; stop_at cuts it short, pause_at
    // waits there until every queued result is out
    task automatic send_image(input int unsigned w, input int unsigned h,
                              input int unsigned stop_at, input int unsigned pause_at);
        int unsigned total;
        fill_style_t style;
        logic        fill;

        total = w * h + w + 1;
        style = fill_style_t'($urandom_range(0, 2));
        for (int unsigned n = 0; n < total; n++)
        begin
            if (stop_at != 0 && n == stop_at)
                break;
            if (pause_at != 0 && n == pause_at)
            begin
                pixel_valid <= 1'b0;
                wait (pending == 0);
                @(negedge clk);
            end
            if (n < w * h)
                fill = ($urandom_range(0, 19) == 0);
            else
                fill = ($urandom_range(0, 4) != 0);
            send_pixel(pick_channel(style), pick_channel(style), pick_channel(style), fill);
        end
    endtask

    // stimulus and verdict
    initial
    begin : stimulus
        int unsigned rand_start;
        int unsigned stop;
        int unsigned pause;
        int          n_frames;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset geometry: first row and six pixels of a 640 wide image, then abandon it
        send_image(cur_w, cur_h, cur_w + 6, 0);

        // smallest image from clamped writes, all-white then a mixed tile
        set_width('0);
        set_height(cfg_word_t'(MIN_DIM - 1));
        write_reg('1, 13'h1555);
        for (int k = 0; k < 9; k++)
            send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        for (int k = 0; k < 4; k++)
            send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
        for (int k = 0; k < 9; k++)
            send_pixel(mixed_tile[k][7:0], mixed_tile[k][15:8], mixed_tile[k][23:16], k == 4);
        send_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
        send_pixel(8'h55, 8'hAA, 8'h55, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);

        // long output hold with the sender at full rate
        set_width(16);
        set_height(6);
        tx_busy = 1'b0;
        sink_hold = HOLD_CYCLES;
        send_image(cur_w, cur_h, 0, 0);

        // sender pauses mid image until all results are out
        tx_busy = 1'b1;
        set_width(8);
        set_height(5);
        send_image(cur_w, cur_h, 0, 17);

        // widest image and tallest image, both cut short
        tx_busy = 1'b0;
        rx_busy = 1'b0;
        set_width('1);
        set_height('0);
        send_image(cur_w, cur_h, cur_w + 40, 0);
        set_height('1);
        set_width(3);
        send_image(cur_w, cur_h, 60, 0);

        // random settings and images
        rand_start = items_sent;
        while (items_sent - rand_start < RANDOM_ITEMS)
        begin
            tx_busy = ($urandom_range(0, 3) != 0);
            rx_busy = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0: write_reg(cfg_idx_t'($urandom_range(REG_IMAGE_HEIGHT + 1,
                                                       (1 << CFG_INDEX_BITS) - 1)),
                             cfg_word_t'($urandom_range(0, (1 << CFG_DATA_BITS) - 1)));
                1: set_height(cfg_word_t'($urandom_range(0, (1 << CFG_DATA_BITS) - 1)));
                2: set_width(cfg_word_t'($urandom_range(0, 40)));
                default:
                begin
                    set_width(cfg_word_t'($urandom_range(MIN_DIM, 12)));
                    set_height(cfg_word_t'($urandom_range(MIN_DIM, 8)));
                end
            endcase
            n_frames = $urandom_range(1, 3);
            for (int f = 0; f < n_frames; f++)
            begin
                // large images and some normal ones are cut short
                if (cur_w * cur_h > 256 || $urandom_range(0, 5) == 0)
                begin
                    stop = $urandom_range(1, 2 * cur_w + 20);
                    send_image(cur_w, cur_h, stop, 0);
                    break;
                end
                pause = ($urandom_range(0, 7) == 0) ? $urandom_range(1, cur_w * cur_h) : 0;
                send_image(cur_w, cur_h, 0, pause);
            end
        end

        // let the last results drain
        pixel_valid <= 1'b0;
        wait (pending == 0);
        repeat (20) @(negedge clk);

        $display("covered %0d pixel items over %0d register writes, sizes 3x3 to 1024 wide",
                 items_sent, reg_writes);
        $display("and 4096 tall, with %0d blurred pixels compared and %0d frames ended",
                 checked, frames_done);
        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
